>>> rtl/core/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL converter.
`timescale 1ns / 1ps

package rgbhsl_pkg;

	localparam int CHAN_W = 8;
	localparam int HUE_W = 9;

	// Hue division: 17-bit numerator, 8-bit divisor (delta), 9 quotient bits.
	localparam int HUE_REM_W = 17;
	localparam int HUE_DIV_W = 8;
	localparam int HUE_Q_BITS = 9;

	// Saturation division: 17-bit numerator, 9-bit divisor, 8 quotient bits.
	localparam int SAT_REM_W = 17;
	localparam int SAT_DIV_W = 9;
	localparam int SAT_Q_BITS = 8;

	// Division steps resolved in each divider stage.
	localparam int STEPS_PER_STAGE = 3;

	localparam int CHAN_MAX = 255;
	localparam int SUM_MAX = 510;
	localparam int DEG_SECTOR = 60;
	localparam int DEG_GREEN = 120;
	localparam int DEG_BLUE = 240;
	localparam int DEG_FULL = 360;
	localparam int HUE_MAX = 359;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue_degrees;
		logic [CHAN_W-1:0] saturation_level;
		logic [CHAN_W-1:0] lightness_level;
		logic [CHAN_W-1:0] alpha_out;
	} hsl_t;

	// Working state of both dividers as it travels down the pipeline.
	typedef struct packed {
		logic [HUE_REM_W-1:0]  hue_rem;
		logic [HUE_DIV_W-1:0]  hue_div;
		logic [HUE_Q_BITS-1:0] hue_quo;
		logic [SAT_REM_W-1:0]  sat_rem;
		logic [SAT_DIV_W-1:0]  sat_div;
		logic [SAT_Q_BITS-1:0] sat_quo;
		logic [CHAN_W-1:0]     lightness;
		logic [CHAN_W-1:0]     alpha;
		logic                  gray;
	} div_state_t;

endpackage

>>> rtl/core/rgb_to_hsl_converter_core.sv
// Top level of the pipelined RGB to HSL pixel converter.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the pix channel (pix_valid, pix_stall, pix) and HSL items
// leave on the hsl channel (hsl_valid, hsl_stall, hsl). An item moves at a
// rising edge where its valid is high and its stall is low.
// The block is a five-register pipeline: a front stage that finds max, min,
// delta, lightness and both division operands; three divider stages that
// each resolve three hue quotient bits and up to three saturation bits; and
// an output register that applies the gray override. An accepted pixel
// passes through these five registers in order before it can be taken
// from hsl.
// Throughput is one item per clock while hsl_stall is low. Each stage
// holds its item only while the stage after it is full and cannot move, so
// bubbles close up and the input is stalled only when all five registers
// hold items and hsl_stall is high. A stall never drops or repeats an item.
// Reset (arst_n low) empties the pipeline at once; payload registers are not
// cleared and there is no other state, since pixels are independent.
// Alpha is carried through unchanged; gray pixels give hue 0 and
// saturation 0.
module rgb_to_hsl_converter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  rgbhsl_pkg::pixel_t pix,
	output logic               hsl_valid,
	input  logic               hsl_stall,
	output rgbhsl_pkg::hsl_t   hsl
);
	import rgbhsl_pkg::*;

	// Front stage signals.
	logic [CHAN_W-1:0]    mx;
	logic [CHAN_W-1:0]    mn;
	logic [CHAN_W-1:0]    dl;
	logic [CHAN_W-1:0]    d_gb;
	logic [CHAN_W-1:0]    d_bg;
	logic [CHAN_W:0]      sum;
	logic [CHAN_W+1:0]    lsum;
	logic [CHAN_W:0]      den_full;
	logic [CHAN_W-1:0]    den;
	logic [HUE_REM_W-1:0] hue_num;
	div_state_t           front;

	// Pipeline registers and the advance chain.
	logic       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic       adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	div_state_t div_s1, div_s2, div_s3, div_s4;
	hsl_t       hsl_s5;
	hsl_t       final_hsl;

	// Largest and smallest channel, delta and the sum used by lightness and
	// saturation.
	always_comb begin
		mx = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		mn = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		dl = mx - mn;
		d_gb = pix.green - pix.blue;
		d_bg = pix.blue - pix.green;
		sum = {1'b0, mx} + {1'b0, mn};
		lsum = {1'b0, sum} + (CHAN_W+2)'(1);
		den_full = (sum <= (CHAN_W+1)'(CHAN_MAX)) ? sum : ((CHAN_W+1)'(SUM_MAX) - sum);
		den = den_full[CHAN_W-1:0];
	end

	// Hue numerator by sextant. Red wins ties over green and green over blue.
	// With red largest and green below blue, the sector value is negative and
	// is wrapped by a full turn so the hue lands in 300..359. The other sums
	// never go negative overall, so modular 17-bit arithmetic is exact.
	always_comb begin
		if (mx == pix.red) begin
			if (pix.green >= pix.blue) begin
				hue_num = HUE_REM_W'(d_gb) * HUE_REM_W'(DEG_SECTOR);
			end else begin
				hue_num = HUE_REM_W'(dl) * HUE_REM_W'(DEG_FULL)
					- HUE_REM_W'(d_bg) * HUE_REM_W'(DEG_SECTOR);
			end
		end else if (mx == pix.green) begin
			hue_num = HUE_REM_W'(dl) * HUE_REM_W'(DEG_GREEN)
				+ HUE_REM_W'(pix.blue) * HUE_REM_W'(DEG_SECTOR)
				- HUE_REM_W'(pix.red) * HUE_REM_W'(DEG_SECTOR);
		end else begin
			hue_num = HUE_REM_W'(dl) * HUE_REM_W'(DEG_BLUE)
				+ HUE_REM_W'(pix.red) * HUE_REM_W'(DEG_SECTOR)
				- HUE_REM_W'(pix.green) * HUE_REM_W'(DEG_SECTOR);
		end
	end

	// Saturation is round(255 * dl / den), done as (510*dl + den) / (2*den).
	// For gray pixels den may be zero; the quotient is then discarded.
	always_comb begin
		front.hue_rem = hue_num;
		front.hue_div = dl;
		front.hue_quo = '0;
		front.sat_rem = SAT_REM_W'(dl) * SAT_REM_W'(SUM_MAX) + SAT_REM_W'(den);
		front.sat_div = {den, 1'b0};
		front.sat_quo = '0;
		front.lightness = lsum[CHAN_W:1];
		front.alpha = pix.alpha;
		front.gray = (dl == '0);
	end

	// A stage may load when it is empty or when its item moves on.
	assign adv_s5 = !valid_s5 || !hsl_stall;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pix_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= pix_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_valid) begin
			div_s1 <= front;
		end
	end

	// Three divider stages resolve quotient bits three at a time, most
	// significant first; the saturation quotient is complete after eight.
	rgbhsl_div_stage #(.FIRST_STEP(0)) u_div_a (
		.clk  (clk),
		.load (adv_s2 && valid_s1),
		.din  (div_s1),
		.dout (div_s2)
	);

	rgbhsl_div_stage #(.FIRST_STEP(STEPS_PER_STAGE)) u_div_b (
		.clk  (clk),
		.load (adv_s3 && valid_s2),
		.din  (div_s2),
		.dout (div_s3)
	);

	rgbhsl_div_stage #(.FIRST_STEP(2 * STEPS_PER_STAGE)) u_div_c (
		.clk  (clk),
		.load (adv_s4 && valid_s3),
		.din  (div_s3),
		.dout (div_s4)
	);

	// Gray pixels force hue and saturation to zero; hue is held to 359.
	always_comb begin
		if (div_s4.gray) begin
			final_hsl.hue_degrees = '0;
			final_hsl.saturation_level = '0;
		end else begin
			final_hsl.hue_degrees = (div_s4.hue_quo > HUE_W'(HUE_MAX)) ?
				HUE_W'(HUE_MAX) : div_s4.hue_quo;
			final_hsl.saturation_level = div_s4.sat_quo;
		end
		final_hsl.lightness_level = div_s4.lightness;
		final_hsl.alpha_out = div_s4.alpha;
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && valid_s4) begin
			hsl_s5 <= final_hsl;
		end
	end

	assign hsl_valid = valid_s5;
	assign hsl = hsl_s5;

`ifndef SYNTHESIS
	// The input is held back only when every stage is full and output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && hsl_stall))
		else $error("input stalled while the pipeline has room");

	// Hue never leaves the 0..359 range.
	assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> (hsl.hue_degrees <= HUE_W'(HUE_MAX)))
		else $error("hue out of range");

	// Any colored pixel has nonzero saturation, so a nonzero hue implies it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hsl_valid && (hsl.hue_degrees != '0)) |-> (hsl.saturation_level != '0))
		else $error("nonzero hue with zero saturation");

	// An item leaving the last divider stage reaches the output register next.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && adv_s5) |=> valid_s5)
		else $error("item lost between divider and output register");
`endif

endmodule

>>> rtl/core/rgbhsl_div_stage.sv
// One registered stage of the hue and saturation restoring dividers.
`timescale 1ns / 1ps

module rgbhsl_div_stage #(
	parameter int FIRST_STEP = 0
) (
	input  logic                   clk,
	input  logic                   load,
	input  rgbhsl_pkg::div_state_t din,
	output rgbhsl_pkg::div_state_t dout
);
	import rgbhsl_pkg::*;

	div_state_t nxt;

	// Each step compares the partial remainder with the shifted divisor and
	// shifts the resulting quotient bit in from the right.
	always_comb begin
		logic [HUE_REM_W-1:0] hcand;
		logic [SAT_REM_W-1:0] scand;
		int j;
		int hsh;
		int ssh;
		nxt = din;
		for (int k = 0; k < STEPS_PER_STAGE; k++) begin
			j = FIRST_STEP + k;
			hsh = (j < HUE_Q_BITS) ? (HUE_Q_BITS - 1 - j) : 0;
			ssh = (j < SAT_Q_BITS) ? (SAT_Q_BITS - 1 - j) : 0;
			hcand = HUE_REM_W'(nxt.hue_div) << hsh;
			scand = SAT_REM_W'(nxt.sat_div) << ssh;
			if (j < HUE_Q_BITS) begin
				if (nxt.hue_rem >= hcand) begin
					nxt.hue_rem = nxt.hue_rem - hcand;
					nxt.hue_quo = {nxt.hue_quo[HUE_Q_BITS-2:0], 1'b1};
				end else begin
					nxt.hue_quo = {nxt.hue_quo[HUE_Q_BITS-2:0], 1'b0};
				end
			end
			if (j < SAT_Q_BITS) begin
				if (nxt.sat_rem >= scand) begin
					nxt.sat_rem = nxt.sat_rem - scand;
					nxt.sat_quo = {nxt.sat_quo[SAT_Q_BITS-2:0], 1'b1};
				end else begin
					nxt.sat_quo = {nxt.sat_quo[SAT_Q_BITS-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dout <= nxt;
		end
	end

endmodule
